>>> rtl/ord_pkg.sv
// Shared types, sizes and helpers for the overwrite ring deque.
// Used by ord_ram's users, ord_ctrl, the top level and the checker.
package ord_pkg;

  localparam int DEPTH     = 64;
  localparam int WORD_BITS = 16;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  localparam int CAP_W     = 7;
  localparam int CAP_RESET = 64;
  localparam int KIND_W    = 2;
  localparam int VAL_W     = 16;
  localparam int LVL_W     = 7;
  localparam int RES_BITS  = 2 * VAL_W + 2 + 2 * LVL_W;
  localparam int OUT_W     = ((RES_BITS + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_BACK  = 2'd0,
    KIND_PUSH_FRONT = 2'd1,
    KIND_POP        = 2'd2,
    KIND_PEEK       = 2'd3
  } kind_t;

  typedef struct packed {
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
  } ram_req_t;

  typedef struct packed {
    logic             sel_data;
    logic             dropped;
    logic             underflow;
    logic [LVL_W-1:0] fill_level;
    logic [LVL_W-1:0] free_space;
  } res_info_t;

  // zero acts as one slot, anything above the built depth as the full depth
  function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (int'(v) > DEPTH) begin
      r = CNT_W'(DEPTH);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage

>>> rtl/ord_ram.sv
// Generic single-clock RAM: one write port, one registered read port.
// Read-first when both ports hit the same entry. No dependencies.
module ord_ram #(
  parameter int DEPTH_P = 64,
  parameter int WIDTH_P = 16
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH_P)-1:0] wr_addr,
  input  logic [WIDTH_P-1:0]         wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH_P)-1:0] rd_addr,
  output logic [WIDTH_P-1:0]         rd_data
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/ord_ctrl.sv
// Pointer and capacity control: front index, fill count, capacity register,
// and the RAM access of each item. Depends on ord_pkg.
module ord_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [ord_pkg::CAP_W-1:0] cfg_wdata,
  input  logic                      acc,
  input  logic [ord_pkg::KIND_W-1:0] kind_in,
  input  logic [ord_pkg::VAL_W-1:0] value_in,
  output ord_pkg::ram_req_t         req,
  output ord_pkg::res_info_t        info
);
  import ord_pkg::*;

  logic [CNT_W-1:0]  cap_r;
  logic [ADDR_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;

  kind_t             kind;
  logic              empty, full;
  logic [CNT_W-1:0]  front_plus;
  logic [ADDR_W-1:0] front_inc, front_dec, head;
  logic [CNT_W:0]    head_sum;

  assign kind  = kind_t'(kind_in);
  assign empty = (fill_r == '0);
  assign full  = (fill_r == cap_r);

  assign front_plus = CNT_W'(front_r) + CNT_W'(1);
  assign front_inc  = (front_plus == cap_r) ? '0 : ADDR_W'(front_plus);
  assign front_dec  = (front_r == '0) ? ADDR_W'(cap_r - CNT_W'(1)) : front_r - ADDR_W'(1);
  assign head_sum   = (CNT_W+1)'(front_r) + (CNT_W+1)'(fill_r);
  assign head       = (head_sum >= (CNT_W+1)'(cap_r)) ?
                      ADDR_W'(head_sum - (CNT_W+1)'(cap_r)) : ADDR_W'(head_sum);

  always_comb begin
    logic wr;
    wr            = 1'b0;
    req.rd_en     = acc;
    req.rd_addr   = front_r;
    req.wr_addr   = front_r;
    req.wr_data   = value_in[WORD_BITS-1:0];
    front_nxt     = front_r;
    fill_nxt      = fill_r;
    info.sel_data = 1'b0;
    info.dropped  = 1'b0;
    info.underflow = 1'b0;
    case (kind)
      KIND_PUSH_BACK: begin
        wr = 1'b1;
        if (full) begin
          // oldest word leaves, new word lands in its slot
          info.dropped = 1'b1;
          front_nxt    = front_inc;
        end else begin
          req.wr_addr = head;
          fill_nxt    = fill_r + CNT_W'(1);
        end
      end
      KIND_PUSH_FRONT: begin
        wr = 1'b1;
        if (full) begin
          info.dropped = 1'b1;
        end else begin
          front_nxt   = front_dec;
          req.wr_addr = front_dec;
          fill_nxt    = fill_r + CNT_W'(1);
        end
      end
      KIND_POP: begin
        if (empty) begin
          info.underflow = 1'b1;
        end else begin
          wr            = 1'b1;
          req.wr_data   = '0;
          info.sel_data = 1'b1;
          front_nxt     = front_inc;
          fill_nxt      = fill_r - CNT_W'(1);
        end
      end
      KIND_PEEK: begin
        info.sel_data = !empty;
      end
      default: begin
        wr = 1'b0;
      end
    endcase
    req.wr_en       = acc & wr;
    info.fill_level = LVL_W'(fill_nxt);
    info.free_space = LVL_W'(cap_r - fill_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= eff_cap(CAP_W'(CAP_RESET));
      front_r <= '0;
      fill_r  <= '0;
    end else if (cfg_we) begin
      if (fill_r == '0) begin
        cap_r   <= eff_cap(cfg_wdata);
        front_r <= '0;
      end
    end else if (acc) begin
      front_r <= front_nxt;
      fill_r  <= fill_nxt;
    end
  end

endmodule

>>> rtl/overwrite_ring_deque_16bit_core.sv
// Overwrite-oldest ring deque of 16-bit words, capacity set by cfg_wdata (1..64).
// An item is taken every cycle unless out_tready stalls stage one, a rate set by
// the single RAM port pair. The front slot is read and the item's slot written in
// accept cycle; the registered read reaches stage one next, then is loaded into the
// register behind out_tvalid. A full push drops the front word and reports it; an
// empty pop returns zero with underflow set. Capacity writes take effect only while
// the queue is empty. The slot memory needs no clearing after reset.
module overwrite_ring_deque_16bit_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [ord_pkg::CAP_W-1:0]  cfg_wdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [ord_pkg::VAL_W-1:0]  in_tdata,   // value
  input  logic [ord_pkg::KIND_W-1:0] in_tuser,   // kind
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // data, dropped, dropped_value, underflow, fill_level, free_space
  output logic [ord_pkg::OUT_W-1:0]  out_tdata
);
  import ord_pkg::*;

  ram_req_t             req;
  res_info_t            info;
  res_info_t            s1_info_r;
  logic                 s1_valid_r, s1_valid_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]     out_data_r;
  logic [WORD_BITS-1:0] rd_data;
  logic [VAL_W-1:0]     word;
  logic                 acc, out_load;
  logic [OUT_W-1:0]     res_word;

  assign out_load   = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready  = ~s1_valid_r | out_load;
  assign acc        = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  ord_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .acc      (acc),
    .kind_in  (in_tuser),
    .value_in (in_tdata),
    .req      (req),
    .info     (info)
  );

  ord_ram #(
    .DEPTH_P(DEPTH),
    .WIDTH_P(WORD_BITS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (req.wr_en),
    .wr_addr(req.wr_addr),
    .wr_data(req.wr_data),
    .rd_en  (req.rd_en),
    .rd_addr(req.rd_addr),
    .rd_data(rd_data)
  );

  assign word = VAL_W'(rd_data);
  assign res_word = OUT_W'({s1_info_r.free_space, s1_info_r.fill_level, s1_info_r.underflow,
                            (s1_info_r.dropped ? word : VAL_W'(0)), s1_info_r.dropped,
                            (s1_info_r.sel_data ? word : VAL_W'(0))});

  assign s1_valid_nxt  = acc | (s1_valid_r & ~out_load);
  assign out_valid_nxt = out_load | (out_valid_r & ~out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // read data stays put while stage one waits, since the RAM reads only on accept
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_info_r <= info;
    end
    if (out_load) begin
      out_data_r <= res_word;
    end
  end

endmodule

>>> rtl/ord_checker.sv
// Port-level checks for the overwrite ring deque, bound to the top level.
// Depends on ord_pkg.
module ord_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [ord_pkg::OUT_W-1:0] out_tdata
);
  import ord_pkg::*;

  logic [VAL_W-1:0] data_f, dval_f;
  logic             drop_f, under_f;
  logic [LVL_W-1:0] fill_f, free_f;

  assign data_f  = out_tdata[15:0];
  assign drop_f  = out_tdata[16];
  assign dval_f  = out_tdata[32:17];
  assign under_f = out_tdata[33];
  assign fill_f  = out_tdata[40:34];
  assign free_f  = out_tdata[47:41];

  a_level_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (int'(fill_f) + int'(free_f) <= DEPTH))
    else $error("fill plus free exceeds depth");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && drop_f) |-> (free_f == '0 && fill_f != '0 && !under_f))
    else $error("drop reported while queue not full");

  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && under_f) |-> (fill_f == '0 && data_f == '0 && !drop_f))
    else $error("underflow with words held or data");

  a_no_drop_val: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !drop_f) |-> (dval_f == '0))
    else $error("dropped value without a drop");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled item changed");

endmodule

bind overwrite_ring_deque_16bit_core ord_checker u_ord_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

>>> test/overwrite_ring_deque_16bit_core_test.sv
`timescale 1ns / 100ps
// Self-checking bench for overwrite_ring_deque_16bit_core: queue ops in, one result out per op.
// A local deque model predicts each result; depends on ord_pkg and the core RTL only.
module overwrite_ring_deque_16bit_core_test;
  import ord_pkg::*;

  // out_tdata layout, lowest bit first: data, dropped, dropped_value, underflow, fill, free
  typedef struct packed {
    logic [LVL_W-1:0] free_space;
    logic [LVL_W-1:0] fill_level;
    logic             underflow;
    logic [VAL_W-1:0] dropped_value;
    logic             dropped;
    logic [VAL_W-1:0] data;
  } deque_result_t;

  typedef struct {
    kind_t            kind;
    logic [VAL_W-1:0] value;
  } deque_op_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CAP_W-1:0]  cfg_wdata = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [VAL_W-1:0]  in_tdata = '0;
  logic [KIND_W-1:0] in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;

  overwrite_ring_deque_16bit_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // local copy of the deque
  logic [VAL_W-1:0] q_store [DEPTH] = '{default: '0};
  logic [CAP_W-1:0] q_capacity = CAP_W'(CAP_RESET);
  int               q_front = 0;
  int               q_fill = 0;

  deque_op_t     pending_ops[$];
  deque_result_t awaited_results[$];

  int error_count = 0;
  int ops_sent = 0;
  int results_checked = 0;
  int drop_count = 0;
  int underflow_count = 0;
  int cap_writes = 0;
  int send_gap_max = 0;
  int stall_max = 0;
  int send_wait = 0;
  int stall_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  function automatic int eff_capacity();
    if (q_capacity == '0) return 1;
    if (int'(q_capacity) > DEPTH) return DEPTH;
    return int'(q_capacity);
  endfunction

  function automatic logic [VAL_W-1:0] take_front(input int cap);
    logic [VAL_W-1:0] v;
    v = q_store[q_front];
    q_store[q_front] = '0;
    q_front = (q_front + 1) % cap;
    q_fill--;
    return v;
  endfunction

  function automatic deque_result_t deque_step(input kind_t kind, input logic [VAL_W-1:0] value);
    deque_result_t r;
    int cap;
    r = '0;
    cap = eff_capacity();
    if (q_fill > cap) q_fill = cap;
    q_front = q_front % cap;
    case (kind)
      KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
        if (q_fill >= cap) begin
          r.dropped = 1'b1;
          r.dropped_value = take_front(cap);
        end
        if (kind == KIND_PUSH_BACK) begin
          q_store[(q_front + q_fill) % cap] = value;
        end else begin
          // front push wraps below slot zero to the top of the used range
          q_front = (q_front == 0) ? cap - 1 : q_front - 1;
          q_store[q_front] = value;
        end
        q_fill++;
      end
      KIND_POP: begin
        if (q_fill == 0) r.underflow = 1'b1;
        else r.data = take_front(cap);
      end
      default: begin
        if (q_fill != 0) r.data = q_store[q_front];
      end
    endcase
    r.fill_level = LVL_W'(q_fill);
    r.free_space = LVL_W'(cap - q_fill);
    return r;
  endfunction

  // capacity write only lands on an empty queue
  function automatic void apply_capacity(input logic [CAP_W-1:0] v);
    if (q_fill == 0) begin
      q_capacity = v;
      q_front = 0;
    end
  endfunction

  // sender
  always @(posedge clk) begin : op_driver
    deque_op_t op;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_wait <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (send_wait != 0) begin
        send_wait <= send_wait - 1;
        in_tvalid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        op = pending_ops.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= op.value;
        in_tuser  <= op.kind;
        send_wait <= $urandom_range(0, send_gap_max);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: a fresh stall is drawn after each accepted result
  always @(posedge clk) begin : result_sink
    int next_stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_tvalid && out_tready) next_stall = $urandom_range(0, stall_max);
      else if (stall_left > 0) next_stall = stall_left - 1;
      else next_stall = 0;
      stall_left <= next_stall;
      out_tready <= (next_stall == 0);
    end
  end

  // prediction on accepted ops, comparison on accepted results
  always @(posedge clk) begin : result_check
    deque_result_t got;
    deque_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (awaited_results.size() == 0) begin
          report_mismatch("result arrived with none outstanding");
        end else begin
          want = awaited_results.pop_front();
          results_checked++;
          check_field("data", got.data, want.data);
          check_field("dropped", got.dropped, want.dropped);
          check_field("dropped_value", got.dropped_value, want.dropped_value);
          check_field("underflow", got.underflow, want.underflow);
          check_field("fill_level", got.fill_level, want.fill_level);
          check_field("free_space", got.free_space, want.free_space);
        end
      end
      if (cfg_we) apply_capacity(cfg_wdata);
      if (in_tvalid && in_tready) begin
        want = deque_step(kind_t'(in_tuser), in_tdata);
        if (want.dropped) drop_count++;
        if (want.underflow) underflow_count++;
        ops_sent++;
        awaited_results.push_back(want);
      end
    end
  end

  task automatic add_op(input kind_t kind, input logic [VAL_W-1:0] value);
    deque_op_t op;
    op.kind = kind;
    op.value = value;
    pending_ops.push_back(op);
  endtask

  // waits until every op is sent and every outstanding result is back, plus pipeline slack
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_ops.size() != 0 || in_tvalid || awaited_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_writes++;
  endtask

  task automatic add_random_ops(input int count);
    int push_pct;
    int r;
    for (int i = 0; i < count; i++) begin
      // fill hard for most of the run, then lean toward draining
      push_pct = (i < count * 3 / 4) ? 92 : 15;
      r = $urandom_range(0, 99);
      if (r < push_pct)
        add_op($urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, VAL_W'($urandom));
      else
        add_op($urandom_range(0, 3) == 0 ? KIND_PEEK : KIND_POP, VAL_W'($urandom));
    end
  endtask

  initial begin : stimulus
    int cap_plan[$];
    int n;
    int gap_choices[3];
    gap_choices = '{0, 3, 18};
    cap_plan = '{1, 0, 127, 2, 3, 64, 65, 5, 4, 17, 33, 8, 1, 64};
    cap_plan.push_back($urandom_range(1, 127));
    cap_plan.push_back($urandom_range(1, 127));

    wait (rst_n);
    send_gap_max = 2;
    stall_max = 2;
    // empty pop and peek, front push at slot zero, value extremes
    add_op(KIND_POP, 16'hFFFF);
    add_op(KIND_PEEK, 16'hFFFF);
    add_op(KIND_PUSH_FRONT, 16'hFFFF);
    add_op(KIND_PUSH_BACK, 16'h0000);
    add_op(KIND_PEEK, 16'h0000);
    add_op(KIND_PUSH_BACK, 16'h8001);
    add_op(KIND_PUSH_FRONT, 16'h7FFE);
    add_op(KIND_POP, 16'h0000);
    add_op(KIND_POP, 16'h0000);
    add_op(KIND_POP, 16'h0000);
    add_op(KIND_POP, 16'h0000);
    add_op(KIND_POP, 16'h0000);
    add_op(KIND_PEEK, 16'h0000);
    add_op(KIND_PUSH_BACK, 16'h1234);
    wait_drained();
    // queue holds one word: this write must be ignored
    write_capacity(7'd3);
    add_op(KIND_PUSH_BACK, 16'hAAAA);
    add_op(KIND_POP, 16'h5555);
    add_op(KIND_POP, 16'h5555);
    add_op(KIND_POP, 16'h5555);

    foreach (cap_plan[p]) begin
      wait_drained();
      // usually empty the queue first; otherwise the write is dropped unless the queue is already empty
      if ($urandom_range(0, 4) != 0) begin
        n = q_fill;
        for (int i = 0; i < n; i++) add_op(KIND_POP, VAL_W'($urandom));
        wait_drained();
      end
      write_capacity(CAP_W'(cap_plan[p]));
      send_gap_max = gap_choices[$urandom_range(0, 2)];
      stall_max = gap_choices[$urandom_range(0, 2)];
      add_random_ops(cap_plan[p] >= 32 ? 70 : 18);
    end

    wait_drained();
    repeat (10) @(negedge clk);
    $display("Ran %0d ops across %0d capacity writes; %0d results checked.",
             ops_sent, cap_writes, results_checked);
    $display("Saw %0d overwrite drops and %0d empty pops.", drop_count, underflow_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("timeout with %0d results outstanding", awaited_results.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> overwrite_ring_deque_16bit_core.f
rtl/ord_pkg.sv
rtl/ord_ram.sv
rtl/ord_ctrl.sv
rtl/overwrite_ring_deque_16bit_core.sv
rtl/ord_checker.sv
test/overwrite_ring_deque_16bit_core_test.sv
